// ===== design/gmhp_pkg.sv =====
`default_nettype none

package gmhp_pkg;

    localparam logic [7:0] MAGIC_ONE   = 8'h1F;
    localparam logic [7:0] MAGIC_TWO   = 8'h8B;
    localparam logic [7:0] METHOD_DEFL = 8'h08;
    localparam logic [15:0] XLEN_SCALE = 16'd256;

    // Bit positions inside the flag byte.
    localparam int FL_HCRC_BIT    = 1;
    localparam int FL_EXTRA_BIT   = 2;
    localparam int FL_NAME_BIT    = 3;
    localparam int FL_COMMENT_BIT = 4;

    typedef enum logic [2:0] {
        ST_HEADER  = 3'd0,
        ST_DONE    = 3'd1,
        ST_PAYLOAD = 3'd2,
        ST_MAGIC   = 3'd3,
        ST_METHOD  = 3'd4,
        ST_TRUNC   = 3'd5
    } status_t;

    typedef enum logic [18:0] {
        PH_ID1     = 19'b000_0000_0000_0000_0001,
        PH_ID2     = 19'b000_0000_0000_0000_0010,
        PH_CM      = 19'b000_0000_0000_0000_0100,
        PH_FLG     = 19'b000_0000_0000_0000_1000,
        PH_MT0     = 19'b000_0000_0000_0001_0000,
        PH_MT1     = 19'b000_0000_0000_0010_0000,
        PH_MT2     = 19'b000_0000_0000_0100_0000,
        PH_MT3     = 19'b000_0000_0000_1000_0000,
        PH_XFL     = 19'b000_0000_0001_0000_0000,
        PH_OS      = 19'b000_0000_0010_0000_0000,
        PH_XLEN_LO = 19'b000_0000_0100_0000_0000,
        PH_XLEN_HI = 19'b000_0000_1000_0000_0000,
        PH_XSKIP   = 19'b000_0001_0000_0000_0000,
        PH_NAME    = 19'b000_0010_0000_0000_0000,
        PH_COMMENT = 19'b000_0100_0000_0000_0000,
        PH_HCRC0   = 19'b000_1000_0000_0000_0000,
        PH_HCRC1   = 19'b001_0000_0000_0000_0000,
        PH_PAYLOAD = 19'b010_0000_0000_0000_0000,
        PH_ERROR   = 19'b100_0000_0000_0000_0000
    } phase_t;

endpackage

`default_nettype wire

// ===== design/gmhp_ifs.sv =====
`default_nettype none

interface gmhp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       new_member;
    logic       stream_end;

    modport source (output valid, output data_byte, output new_member, output stream_end,
                    input ready);
    modport sink (input valid, input data_byte, input new_member, input stream_end,
                  output ready);
endinterface

interface gmhp_result_if;
    logic                  valid;
    logic                  ready;
    gmhp_pkg::status_t     status;
    logic [7:0]            payload_byte;
    logic [7:0]            header_flags;
    logic [31:0]           modify_time;

    modport source (output valid, output status, output payload_byte, output header_flags,
                    output modify_time, input ready);
    modport sink (input valid, input status, input payload_byte, input header_flags,
                  input modify_time, output ready);
endinterface

`default_nettype wire

// ===== design/gzip_member_header_parser.sv =====
// gzip member header parser.
// The bytes channel carries one byte of a gzip member per transaction, with
// new_member marking the first byte of a member and stream_end the last byte
// of the stream. The results channel returns exactly one transaction for
// every byte: a status code, the byte itself when it is payload, and the flag
// byte and modification time as known after that byte.
// Each byte passes through an input register and is then parsed into the result
// register, which holds the result until the receiver accepts it. One byte per
// cycle is sustained while the receiver keeps accepting results; the single
// parse step with its phase register and skip counter sets that rate.
// Reset returns the parser to the first magic byte with flags, time and the
// error code cleared, and empties both registers.
// When the receiver stalls, the result register holds its transaction and the
// input register holds or takes at most one more byte; after that, bytes is
// held not ready until results moves again.

`default_nettype none

module gzip_member_header_parser (
    input  wire            clk,
    input  wire            rst_n,
    gmhp_byte_if.sink      bytes,
    gmhp_result_if.source  results
);
    import gmhp_pkg::*;

    gmhp_byte_if stage_ch ();

    gmhp_in_reg u_in_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .bytes (bytes),
        .stage (stage_ch.source)
    );

    gmhp_parse u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .stage   (stage_ch.sink),
        .results (results)
    );

endmodule

`default_nettype wire

// ===== design/gmhp_in_reg.sv =====
`default_nettype none

module gmhp_in_reg (
    input  wire          clk,
    input  wire          rst_n,
    gmhp_byte_if.sink    bytes,
    gmhp_byte_if.source  stage
);
    import gmhp_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       member_reg;
    logic       end_reg;
    logic       take;

    // The register frees up in the same cycle its content moves on.
    assign bytes.ready = !valid_reg || stage.ready;
    assign take        = bytes.valid && bytes.ready;

    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (stage.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg   <= bytes.data_byte;
            member_reg <= bytes.new_member;
            end_reg    <= bytes.stream_end;
        end
    end

    assign stage.valid      = valid_reg;
    assign stage.data_byte  = data_reg;
    assign stage.new_member = member_reg;
    assign stage.stream_end = end_reg;

endmodule

`default_nettype wire

// ===== design/gmhp_parse.sv =====
`default_nettype none

module gmhp_parse (
    input  wire            clk,
    input  wire            rst_n,
    gmhp_byte_if.sink      stage,
    gmhp_result_if.source  results
);
    import gmhp_pkg::*;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [15:0] skip_reg;
    logic [15:0] skip_next;
    logic [7:0]  flag_reg;
    logic [7:0]  flag_next;
    logic [31:0] time_reg;
    logic [31:0] time_next;
    status_t     err_reg;
    status_t     err_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    status_t     status_reg;
    status_t     status_next;
    logic [7:0]  payload_reg;
    logic [7:0]  payload_next;

    logic        advance;
    phase_t      ph;
    phase_t      nxt;
    logic [15:0] skip_cur;
    logic [15:0] skip_dec;
    logic [7:0]  flag_cur;
    logic [31:0] time_cur;
    status_t     err_cur;
    status_t     st;
    logic [7:0]  b;

    function automatic phase_t after_comment(input logic [7:0] fl);
        phase_t r;
        r = fl[FL_HCRC_BIT] ? PH_HCRC0 : PH_PAYLOAD;
        return r;
    endfunction

    function automatic phase_t after_name(input logic [7:0] fl);
        phase_t r;
        r = fl[FL_COMMENT_BIT] ? PH_COMMENT : after_comment(fl);
        return r;
    endfunction

    function automatic phase_t after_xskip(input logic [7:0] fl);
        phase_t r;
        r = fl[FL_NAME_BIT] ? PH_NAME : after_name(fl);
        return r;
    endfunction

    function automatic phase_t after_os(input logic [7:0] fl);
        phase_t r;
        r = fl[FL_EXTRA_BIT] ? PH_XLEN_LO : after_xskip(fl);
        return r;
    endfunction

    assign stage.ready = !out_valid_reg || results.ready;
    assign advance     = stage.valid && stage.ready;
    assign b           = stage.data_byte;

    always_comb
    begin
        // A new member clears all parser state before its first byte is looked at.
        ph       = stage.new_member ? PH_ID1 : phase_reg;
        skip_cur = stage.new_member ? 16'd0 : skip_reg;
        flag_cur = stage.new_member ? 8'd0 : flag_reg;
        time_cur = stage.new_member ? 32'd0 : time_reg;
        err_cur  = stage.new_member ? ST_HEADER : err_reg;
        skip_dec = skip_cur - 16'd1;

        st         = ST_HEADER;
        nxt        = ph;
        phase_next = ph;
        skip_next  = skip_cur;
        flag_next  = flag_cur;
        time_next  = time_cur;
        err_next   = err_cur;

        case (ph)
            PH_ERROR:
            begin
                st = err_cur;
            end
            PH_ID1:
            begin
                if (b != MAGIC_ONE)
                begin
                    st = ST_MAGIC;
                end
                else
                begin
                    nxt = PH_ID2;
                end
            end
            PH_ID2:
            begin
                if (b != MAGIC_TWO)
                begin
                    st = ST_MAGIC;
                end
                else
                begin
                    nxt = PH_CM;
                end
            end
            PH_CM:
            begin
                if (b != METHOD_DEFL)
                begin
                    st = ST_METHOD;
                end
                else
                begin
                    nxt = PH_FLG;
                end
            end
            PH_FLG:
            begin
                flag_next = b;
                nxt       = PH_MT0;
            end
            PH_MT0:
            begin
                time_next[7:0] = time_cur[7:0] | b;
                nxt            = PH_MT1;
            end
            PH_MT1:
            begin
                time_next[15:8] = time_cur[15:8] | b;
                nxt             = PH_MT2;
            end
            PH_MT2:
            begin
                time_next[23:16] = time_cur[23:16] | b;
                nxt              = PH_MT3;
            end
            PH_MT3:
            begin
                time_next[31:24] = time_cur[31:24] | b;
                nxt              = PH_XFL;
            end
            PH_XFL:
            begin
                nxt = PH_OS;
            end
            PH_OS:
            begin
                nxt = after_os(flag_cur);
            end
            PH_XLEN_LO:
            begin
                skip_next = {8'd0, b};
                nxt       = PH_XLEN_HI;
            end
            PH_XLEN_HI:
            begin
                skip_next = skip_cur + (XLEN_SCALE * {8'd0, b});
                // An empty extra field is skipped at once.
                nxt = (skip_next != 16'd0) ? PH_XSKIP : after_xskip(flag_cur);
            end
            PH_XSKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == 16'd0)
                begin
                    nxt = after_xskip(flag_cur);
                end
            end
            PH_NAME:
            begin
                if (b == 8'd0)
                begin
                    nxt = after_name(flag_cur);
                end
            end
            PH_COMMENT:
            begin
                if (b == 8'd0)
                begin
                    nxt = after_comment(flag_cur);
                end
            end
            PH_HCRC0:
            begin
                nxt = PH_HCRC1;
            end
            PH_HCRC1:
            begin
                nxt = PH_PAYLOAD;
            end
            default:
            begin
                st  = ST_PAYLOAD;
                nxt = PH_PAYLOAD;
            end
        endcase

        if (ph != PH_ERROR)
        begin
            if (st == ST_MAGIC || st == ST_METHOD)
            begin
                err_next   = st;
                phase_next = PH_ERROR;
            end
            else if (st == ST_HEADER)
            begin
                if (nxt == PH_PAYLOAD)
                begin
                    st         = ST_DONE;
                    phase_next = PH_PAYLOAD;
                end
                else if (stage.stream_end)
                begin
                    // The stream stops while the header is still open.
                    st         = ST_TRUNC;
                    err_next   = ST_TRUNC;
                    phase_next = PH_ERROR;
                end
                else
                begin
                    phase_next = nxt;
                end
            end
            else
            begin
                phase_next = nxt;
            end
        end

        status_next  = st;
        payload_next = (st == ST_PAYLOAD) ? b : 8'd0;

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_ID1;
            skip_reg      <= 16'd0;
            flag_reg      <= 8'd0;
            time_reg      <= 32'd0;
            err_reg       <= ST_HEADER;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                phase_reg <= phase_next;
                skip_reg  <= skip_next;
                flag_reg  <= flag_next;
                time_reg  <= time_next;
                err_reg   <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg  <= status_next;
            payload_reg <= payload_next;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.status       = status_reg;
    assign results.payload_byte = payload_reg;
    // Flags and time are state registers already; they change only with a new result.
    assign results.header_flags = flag_reg;
    assign results.modify_time  = time_reg;

    a_err_latched : assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ERROR |->
            (err_reg == ST_MAGIC || err_reg == ST_METHOD || err_reg == ST_TRUNC))
        else $error("error phase without a latched error code");

    a_err_clear : assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_ERROR |-> err_reg == ST_HEADER)
        else $error("error code latched outside the error phase");

    a_skip_live : assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_XSKIP |-> skip_reg != 16'd0)
        else $error("extra field skip entered with nothing left to skip");

    a_done_payload : assert property (@(posedge clk) disable iff (!rst_n)
        advance && status_next == ST_DONE |=>
            phase_reg == PH_PAYLOAD && status_reg == ST_DONE && out_valid_reg)
        else $error("header completion did not move the parser to payload");

endmodule

`default_nettype wire
